// ===== rtl/assert_macros.svh =====
// Assertion macros for the string hash block.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(label, clk, rst, prop, msg)

`define ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

// ===== rtl/ppsh_pkg.sv =====
// Shared types and constants of the positional power string hash.
// No dependencies.
package ppsh_pkg;

  localparam int unsigned HASH_W  = 32;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [HASH_W-1:0] RESET_MULTIPLIER = 32'd6293815;

  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_BLANKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD_CASE     = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'd97;
  localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'd122;
  localparam logic [CHAR_W-1:0] CASE_DIST  = 8'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POS,
    ST_CHR,
    ST_POW
  } state_t;

  typedef enum logic [1:0] {
    MUL_POS,
    MUL_CHR,
    MUL_POW
  } mul_sel_t;

endpackage

// ===== rtl/ppsh_if.sv =====
// Handshake channels of the string hash: character input and hash output.
// Depends on ppsh_pkg for widths.
interface ppsh_char_if;
  import ppsh_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  logic              end_of_string;

  modport source (output valid, output ch, output end_of_string, input ready);
  modport sink   (input valid, input ch, input end_of_string, output ready);
endinterface

interface ppsh_hash_if;
  import ppsh_pkg::*;
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash;

  modport source (output valid, output hash, input ready);
  modport sink   (input valid, input hash, output ready);
endinterface

// ===== rtl/positional_power_string_hash.sv =====
// Positional power string hash: top level with sequencer and shared multiplier.
// Depends on ppsh_pkg, ppsh_if.sv and assert_macros.svh.
//
//   channel   dir  payload               transfer
//   char_in   in   ch, end_of_string     valid && ready
//   hash_out  out  hash                  valid && ready
//   cfg       in   cfg_index, cfg_wdata  cfg_we
//
// A hashed character is accepted in ST_IDLE, then passes through ST_POS, ST_CHR
// and ST_POW, using the one 32x32 multiplier for power*position, *char and
// power*multiplier. Skipped blanks and end items leave the state in ST_IDLE.
// The hash sits in an output register; a new string starts while it waits,
// only an end item stalls. Reset is synchronous and needs no clearing pass.
`include "assert_macros.svh"

module positional_power_string_hash (
  input  logic                            clk,
  input  logic                            rst,
  ppsh_char_if.sink                       char_in,
  ppsh_hash_if.source                     hash_out,
  input  logic                            cfg_we,
  input  logic [ppsh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppsh_pkg::HASH_W-1:0]     cfg_wdata
);
  import ppsh_pkg::*;

  state_t            state, state_next;
  mul_sel_t          mul_sel;

  logic [HASH_W-1:0] multiplier;
  logic              ignore_blanks;
  logic              fold_case;

  logic [HASH_W-1:0] running_sum;
  logic [HASH_W-1:0] running_power;
  logic [HASH_W-1:0] position;
  logic [HASH_W-1:0] partial;
  logic [CHAR_W-1:0] chr;

  logic              out_valid;
  logic [HASH_W-1:0] out_hash;

  logic              in_xfer;
  logic              end_xfer;
  logic              char_start;
  logic              pos_one;
  logic              is_blank;
  logic              is_lower;
  logic [CHAR_W-1:0] ch_fold;

  logic [HASH_W-1:0] mul_a, mul_b;
  logic [HASH_W-1:0] mul_p;

  assign char_in.ready = (state == ST_IDLE) &&
                         !(char_in.end_of_string && out_valid && !hash_out.ready);
  assign in_xfer    = char_in.valid && char_in.ready;
  assign end_xfer   = in_xfer && char_in.end_of_string;
  assign char_start = in_xfer && !char_in.end_of_string && !(ignore_blanks && is_blank);
  assign pos_one    = (position == {{(HASH_W-1){1'b0}}, 1'b1});

  assign is_blank = ((char_in.ch >= CHAR_TAB) && (char_in.ch <= CHAR_CR)) ||
                    (char_in.ch == CHAR_SPACE);
  assign is_lower = (char_in.ch >= CHAR_LOW_A) && (char_in.ch <= CHAR_LOW_Z);
  assign ch_fold  = (fold_case && is_lower) ? (char_in.ch - CASE_DIST) : char_in.ch;

  assign hash_out.valid = out_valid;
  assign hash_out.hash  = out_hash;

  // shared multiplier, low word kept
  always_comb begin
    unique case (mul_sel)
      MUL_POS: begin
        mul_a = running_power;
        mul_b = position;
      end
      MUL_CHR: begin
        mul_a = partial;
        mul_b = {{(HASH_W-CHAR_W){1'b0}}, chr};
      end
      MUL_POW: begin
        mul_a = running_power;
        mul_b = multiplier;
      end
      default: begin
        mul_a = running_power;
        mul_b = multiplier;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_sel    = MUL_POW;
    unique case (state)
      ST_IDLE: begin
        if (char_start) begin
          state_next = ST_POS;
        end
      end
      ST_POS: begin
        mul_sel    = MUL_POS;
        state_next = ST_CHR;
      end
      ST_CHR: begin
        mul_sel    = MUL_CHR;
        state_next = ST_POW;
      end
      ST_POW: begin
        mul_sel    = MUL_POW;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier    <= RESET_MULTIPLIER;
      ignore_blanks <= 1'b0;
      fold_case     <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_MULTIPLIER) begin
        multiplier <= cfg_wdata;
      end
      if (cfg_index == REG_IGNORE_BLANKS) begin
        ignore_blanks <= cfg_wdata[0];
      end
      if (cfg_index == REG_FOLD_CASE) begin
        fold_case <= cfg_wdata[0];
      end
    end
  end

  // running state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      running_power <= RESET_MULTIPLIER;
      position      <= {{(HASH_W-1){1'b0}}, 1'b1};
    end else if (end_xfer) begin
      running_sum   <= '0;
      running_power <= multiplier;
      position      <= {{(HASH_W-1){1'b0}}, 1'b1};
    end else if (cfg_we && (cfg_index == REG_MULTIPLIER) && pos_one &&
                 (running_sum == '0)) begin
      running_power <= cfg_wdata;
    end else begin
      unique case (state)
        ST_CHR: running_sum <= running_sum + mul_p;
        ST_POW: begin
          running_power <= mul_p;
          position      <= position + {{(HASH_W-1){1'b0}}, 1'b1};
        end
        ST_IDLE, ST_POS: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_POS) begin
      partial <= mul_p;
    end
    if (in_xfer) begin
      chr <= ch_fold;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (end_xfer) begin
      out_valid <= 1'b1;
    end else if (hash_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_xfer) begin
      out_hash <= running_sum;
    end
  end

  `ASSERT_RST(a_busy, clk, rst, (state != ST_IDLE) |-> !char_in.ready, "ready while busy")
  `ASSERT_RST(a_res_src, clk, rst, $rose(out_valid) |-> $past(end_xfer), "stray result")
  `ASSERT_RST(a_restart, clk, rst, end_xfer |=> (running_sum == '0) && pos_one, "no restart")
  `ASSERT_RST(a_start, clk, rst, char_start |=> (state == ST_POS), "no sequence start")

endmodule

// ===== tb/sv/ppsh_hash_checker.sv =====
// Checker for the positional power string hash: predicts each string's hash
// from observed character transfers and register writes, compares hash transfers.
// Depends on ppsh_pkg and the channel interfaces in ppsh_if.sv.
module ppsh_hash_checker
  import ppsh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  ppsh_char_if                 char_in,
  ppsh_hash_if                 hash_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HASH_W-1:0]    cfg_wdata,
  output int                   errors,
  output int                   pending,
  output int                   hashes_checked
);

  logic [HASH_W-1:0] multiplier;
  logic              skip_blanks;
  logic              upper_case;
  logic [HASH_W-1:0] sum;
  logic [HASH_W-1:0] power;
  logic [HASH_W-1:0] pos;
  logic [HASH_W-1:0] expected_hashes[$];

  function automatic logic is_space(logic [CHAR_W-1:0] c);
    return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
  endfunction

  function automatic void restart_string();
    sum   = '0;
    power = multiplier;
    pos   = 1;
  endfunction

  function automatic void absorb_char(logic [CHAR_W-1:0] raw);
    logic [HASH_W-1:0] c;
    c = HASH_W'(raw);
    if (skip_blanks && is_space(raw)) return;
    if (upper_case && raw >= CHAR_LOW_A && raw <= CHAR_LOW_Z) c = c - HASH_W'(CASE_DIST);
    sum   = sum + power * pos * c;
    power = power * multiplier;
    pos   = pos + 1;
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [HASH_W-1:0] val);
    case (idx)
      REG_MULTIPLIER: begin
        multiplier = val;
        // power reloads only when no character has been hashed yet
        if (pos == 1 && sum == '0) power = val;
      end
      REG_IGNORE_BLANKS: skip_blanks = val[0];
      REG_FOLD_CASE:     upper_case  = val[0];
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string what, logic [HASH_W-1:0] want,
                                        logic [HASH_W-1:0] got);
    errors++;
    if (errors <= 10)
      $display("[%0t] %s: expected %08h, got %08h", $realtime, what, want, got);
  endfunction

  always @(posedge clk) begin
    logic [HASH_W-1:0] want;
    if (rst) begin
      multiplier  = RESET_MULTIPLIER;
      skip_blanks = 1'b0;
      upper_case  = 1'b0;
      restart_string();
      expected_hashes.delete();
    end else begin
      if (hash_out.valid && hash_out.ready) begin
        if (expected_hashes.size() == 0) begin
          note_mismatch("hash transfer with none outstanding", '0, hash_out.hash);
        end else begin
          want = expected_hashes.pop_front();
          hashes_checked++;
          if (hash_out.hash !== want) note_mismatch("hash", want, hash_out.hash);
        end
      end
      if (char_in.valid && char_in.ready) begin
        if (char_in.end_of_string) begin
          expected_hashes.push_back(sum);
          restart_string();
        end else begin
          absorb_char(char_in.ch);
        end
      end
      if (cfg_we) apply_write(cfg_index, cfg_wdata);
    end
    pending = expected_hashes.size();
  end

endmodule

// ===== tb/sv/positional_power_string_hash_test.sv =====
// Top of the string hash testbench: clock, reset, character and register
// stimulus, hash consumer and verdict. Uses ppsh_pkg, ppsh_if.sv, ppsh_hash_checker.
module positional_power_string_hash_test;
  import ppsh_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 156;
  localparam int IDLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
  localparam logic [CHAR_W-1:0]    CHAR_UPPER_A = CHAR_LOW_A - CASE_DIST;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [HASH_W-1:0]    cfg_wdata;

  int errors;
  int pending;
  int hashes_checked;
  int cycle_count = 0;
  int n_chars = 0;
  int n_ends = 0;
  bit send_steady = 1'b0;
  bit take_steady = 1'b0;

  ppsh_char_if char_if ();
  ppsh_hash_if hash_if ();

  always #4 clk = ~clk;

  positional_power_string_hash dut (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_if),
    .hash_out  (hash_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ppsh_hash_checker hash_check (
    .clk            (clk),
    .rst            (rst),
    .char_in        (char_if),
    .hash_out       (hash_if),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .errors         (errors),
    .pending        (pending),
    .hashes_checked (hashes_checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 7))
      0: return CHAR_W'(CHAR_LOW_A + $urandom_range(0, 25));
      1: return CHAR_W'(CHAR_UPPER_A + $urandom_range(0, 25));
      2: return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_W'(CHAR_TAB + $urandom_range(0, 4));
      3: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
      default: return CHAR_W'($urandom);
    endcase
  endfunction

  // leaves valid high after the transfer; the next call or settle() decides
  task automatic send_item(input logic [CHAR_W-1:0] c, input logic eos);
    int gap;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_if.valid         <= 1'b1;
    char_if.ch            <= c;
    char_if.end_of_string <= eos;
    do @(posedge clk); while (!char_if.ready);
    @(negedge clk);
    if (eos) n_ends++;
    else n_chars++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HASH_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic settle();
    char_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (IDLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int stall;
    hash_if.ready <= 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 14) == 0) take_steady = !take_steady;
      stall = take_steady ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        hash_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      hash_if.ready <= 1'b1;
      do @(posedge clk); while (!hash_if.valid);
      @(negedge clk);
    end
  end

  initial begin
    int items;
    int len;
    logic [HASH_W-1:0] mult;
    char_if.valid         <= 1'b0;
    char_if.ch            <= '0;
    char_if.end_of_string <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_MULTIPLIER;
    cfg_wdata             <= '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: empty string, byte extremes, blanks hashed as characters
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CHAR_LOW_A, 1'b0);
    send_item(CHAR_LOW_Z, 1'b0);
    send_item(CHAR_UPPER_A, 1'b0);
    send_item(CHAR_TAB, 1'b0);
    send_item(CHAR_CR, 1'b0);
    send_item(CHAR_SPACE, 1'b0);
    send_item(8'h00, 1'b1);
    settle();

    // skip blanks and fold case; neighbors of both ranges, trailing blanks
    write_reg(REG_IGNORE_BLANKS, 32'd1);
    write_reg(REG_FOLD_CASE, 32'd1);
    cfg_we <= 1'b0;
    send_item(CHAR_SPACE, 1'b0);
    send_item(CHAR_LOW_A, 1'b0);
    send_item(CHAR_LOW_A - 8'd1, 1'b0);
    send_item(CHAR_LOW_Z + 8'd1, 1'b0);
    send_item(CHAR_TAB - 8'd1, 1'b0);
    send_item(CHAR_CR + 8'd1, 1'b0);
    send_item(CHAR_LOW_Z, 1'b0);
    send_item(CHAR_CR, 1'b0);
    send_item(CHAR_SPACE, 1'b0);
    send_item(8'h55, 1'b1);
    settle();

    // multiplier change in mid-string
    send_item(CHAR_LOW_Z - 8'd2, 1'b0);
    send_item(CHAR_LOW_Z - 8'd1, 1'b0);
    settle();
    write_reg(REG_MULTIPLIER, '1);
    cfg_we <= 1'b0;
    send_item(CHAR_LOW_A + 8'd16, 1'b0);
    send_item(8'h00, 1'b1);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: mult = '0;
        1: mult = 32'd1;
        2: mult = '1;
        3: mult = 32'h8000_0000;
        4: mult = RESET_MULTIPLIER;
        default: mult = $urandom;
      endcase
      if ($urandom_range(0, 1)) write_reg(REG_UNUSED, $urandom);
      write_reg(REG_IGNORE_BLANKS, {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0, ph[0]});
      write_reg(REG_MULTIPLIER, mult);
      write_reg(REG_FOLD_CASE, {(HASH_W-1)'($urandom), ph[1]});
      cfg_we <= 1'b0;
      items = 0;
      while (items < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        repeat (len) send_item(pick_char(), 1'b0);
        items += len;
        // a phase may end inside a string so the next multiplier write lands mid-string
        if (items < PHASE_ITEMS || $urandom_range(0, 2) != 0) begin
          send_item(CHAR_W'($urandom), 1'b1);
          items++;
        end
      end
      settle();
    end

    send_item(CHAR_W'($urandom), 1'b1);
    settle();

    $display("Checked %0d hashes over %0d characters and %0d string ends,", hashes_checked,
             n_chars, n_ends);
    $display("under reset, directed and %0d random register settings.", PHASES);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
